>>> sv/double_ended_queue_core_macros.svh
// Assertion macros used by the checker of the deque core.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/deq_pkg.sv
package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int MODE_W = 3;
   localparam int ELEM_W = 32;
   localparam int STAT_W = 2;
   localparam int COUNT_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_DUMP_FWD   = 3'd4,
      MODE_DUMP_BACK  = 3'd5
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_ELEM  = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DUMP = 1'b1
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic dump_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic empty;
      logic dump_last;
   } sts_type;

endpackage

>>> sv/deq_ctrl.sv
module deq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_mode,
   input  deq_pkg::sts_type sts,
   output deq_pkg::cmd_type cmd
);
   import deq_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      is_dump;

   assign is_dump = (mode_type'(req_mode) == MODE_DUMP_FWD) ||
                    (mode_type'(req_mode) == MODE_DUMP_BACK);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = sts.out_free;
            if (req_valid && sts.out_free) begin
               cmd.accept = 1'b1;
               if (is_dump && !sts.empty) begin
                  state_in = ST_DUMP;
               end
            end
         end
         ST_DUMP: begin
            if (sts.out_free) begin
               cmd.dump_step = 1'b1;
               if (sts.dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/deq_datapath.sv
module deq_datapath (
   input  logic               clock,
   input  logic               reset,
   input  deq_pkg::cmd_type   cmd,
   output deq_pkg::sts_type   sts,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_element,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_count,
   output logic               rsp_last
);
   import deq_pkg::*;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             dir_back_ff, dir_back_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0]     rsp_element_ff, rsp_element_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             full;
   logic             load;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      ring_next = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
      ring_prev = (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
   endfunction

   assign full          = (count_ff == CNT_W'(DEPTH));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign sts.empty     = (count_ff == '0);
   assign sts.dump_last = ((idx_ff + 1'b1) == count_ff);

   always_comb begin
      front_in       = front_ff;
      back_in        = back_ff;
      count_in       = count_ff;
      slot_in        = slot_ff;
      idx_in         = idx_ff;
      dir_back_in    = dir_back_ff;
      wr_en          = 1'b0;
      wr_addr        = back_ff;
      load           = 1'b0;
      rsp_element_in = '0;
      rsp_status_in  = STAT_DONE;
      rsp_count_in   = count_ff;
      rsp_last_in    = 1'b1;

      if (cmd.accept) begin
         case (mode_type'(req_mode))
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
               load = 1'b1;
               if (full) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (mode_type'(req_mode) == MODE_PUSH_FRONT) begin
                     front_in = ring_prev(front_ff);
                     wr_addr  = ring_prev(front_ff);
                  end else begin
                     back_in = ring_next(back_ff);
                  end
                  rsp_count_in = count_ff + 1'b1;
               end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
               load = 1'b1;
               if (sts.empty) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
                  if (mode_type'(req_mode) == MODE_POP_FRONT) begin
                     front_in = ring_next(front_ff);
                  end else begin
                     back_in = ring_prev(back_ff);
                  end
                  rsp_count_in = count_ff - 1'b1;
               end
            end
            MODE_DUMP_FWD, MODE_DUMP_BACK: begin
               if (sts.empty) begin
                  load          = 1'b1;
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  dir_back_in = (mode_type'(req_mode) == MODE_DUMP_BACK);
                  slot_in     = (mode_type'(req_mode) == MODE_DUMP_BACK) ?
                                ring_prev(back_ff) : front_ff;
                  idx_in      = '0;
               end
            end
            default: begin
               load = 1'b1;
            end
         endcase
      end else if (cmd.dump_step) begin
         load           = 1'b1;
         rsp_element_in = ELEM_W'(rd_data_ff);
         rsp_status_in  = STAT_ELEM;
         rsp_last_in    = sts.dump_last;
         slot_in        = dir_back_ff ? ring_prev(slot_ff) : ring_next(slot_ff);
         idx_in         = idx_ff + 1'b1;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // The read address is the next dump slot, so during a dump rd_data_ff holds the element at slot_ff.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= DATA_WIDTH'($unsigned(req_value));
      end
      rd_data_ff <= mem[slot_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         slot_ff      <= '0;
         idx_ff       <= '0;
         dir_back_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         idx_ff       <= idx_in;
         dir_back_ff  <= dir_back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_element_ff <= rsp_element_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_count   = COUNT_W'(rsp_count_ff);
   assign rsp_last    = rsp_last_ff;

endmodule

>>> sv/double_ended_queue_core.sv
// Channel  | Direction | Handshake              | Beat payload
// req_     | in        | req_valid / req_ready  | req_mode, req_value
// rsp_     | out       | rsp_valid / rsp_ready  | rsp_element, rsp_status, rsp_count, rsp_last
//
// For push, pop and unused modes the result beat is registered at the accept edge.
// A dump of N elements first starts the ring read, then returns one element per cycle while
// the output does not stall, set by the single registered read port of the element store.
// Reset clears the ring indices, the element count, the controller and the output valid.
// The element store is not cleared; it has no clearing pass.
// A low rsp_ready while rsp_valid is high holds the output register and stalls both new requests and a running dump.
module double_ended_queue_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_element,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_count,
   output logic               rsp_last
);
   import deq_pkg::*;

   // Commands flow from the controller to the datapath, status flows back.
   cmd_type cmd;
   sts_type sts;

   // The controller owns the request handshake and sequences dumps.
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the ring store, its indices and count, and the result register.
   deq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_mode    (req_mode),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_element (rsp_element),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count),
      .rsp_last    (rsp_last)
   );

endmodule

>>> sv/deq_checker.sv
`include "double_ended_queue_core_macros.svh"

module deq_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_element,
   input logic [1:0]         rsp_status,
   input logic [4:0]         rsp_count,
   input logic               rsp_last
);
   import deq_pkg::*;

   `DEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_element) && $stable(rsp_status) && $stable(rsp_count) &&
      $stable(rsp_last), "result beat changed while stalled")
   `DEQ_ASSERT_NOW(a_elem_zero, rsp_valid && (rsp_status != STAT_ELEM),
      rsp_element == '0, "non-dump result carries an element")
   `DEQ_ASSERT_NOW(a_empty_beat, rsp_valid && (rsp_status == STAT_EMPTY),
      (rsp_count == '0) && rsp_last, "empty result has a count or is not last")
   `DEQ_ASSERT_NOW(a_full_beat, rsp_valid && (rsp_status == STAT_FULL),
      rsp_count == 5'(DEPTH), "dropped push reports a count below capacity")
   `DEQ_ASSERT_NOW(a_count_range, rsp_valid,
      rsp_count <= 5'(DEPTH), "count beyond capacity")

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);
